### design/rbd_pkg.sv
package rbd_pkg;

  typedef struct packed {
    logic signed [31:0] id;
    logic        [31:0] grade;
  } rec_t;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } op_t;

  // What one cell loads at the next edge.
  typedef enum logic [3:0] {
    CELL_HOLD       = 4'b0001,
    CELL_FROM_LEFT  = 4'b0010,
    CELL_FROM_RIGHT = 4'b0100,
    CELL_LOAD       = 4'b1000
  } cell_op_t;

  // Control broadcast to one chain of cells.
  typedef struct packed {
    logic ins_head;   // shift toward the tail and load a new record at cell 0
    logic drop_head;  // shift toward cell 0, the head record falls out
    logic put_tail;   // load a new record at the cell just past the last one
  } chain_ctl_t;

endpackage

### design/ring_buffer_deque_top.sv
// An item's result is registered and shown in the cycle after the item is accepted.
// One item per cycle unless a result is held; an op is at most a shift and a load in
// two rows of DEPTH record cells, one row ordered from the front and one from the back.
// Reset (rst_n low, synchronous) empties the deque and drops any pending result;
// the record cells are not cleared, since no empty cell is ever shown.
module ring_buffer_deque_top #(
  parameter int DEPTH = 16,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_opcode,
  input  logic signed [31:0] in_student_id,
  input  logic [31:0]        in_grade_bits,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ok,
  output logic [CNT_W-1:0]   out_count,
  output logic               out_not_empty,
  output logic signed [31:0] out_front_id,
  output logic [31:0]        out_front_grade,
  output logic signed [31:0] out_back_id,
  output logic [31:0]        out_back_grade
);
  import rbd_pkg::*;

  logic             accept;
  logic             full;
  logic             empty;
  logic             push_f;
  logic             push_b;
  logic             pop_f;
  logic             pop_b;
  logic             ok;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             out_valid_r;
  logic             out_ok_r;
  rec_t             new_rec;
  rec_t             front_rec;
  rec_t             back_rec;
  chain_ctl_t       front_ctl;
  chain_ctl_t       back_ctl;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign new_rec  = '{id: in_student_id, grade: in_grade_bits};

  always_comb begin
    push_f = 1'b0;
    push_b = 1'b0;
    pop_f  = 1'b0;
    pop_b  = 1'b0;
    ok     = !empty;
    case (op_t'(in_opcode))
      OP_PUSH_FRONT: begin
        push_f = accept && !full;
        ok     = !full;
      end
      OP_PUSH_BACK: begin
        push_b = accept && !full;
        ok     = !full;
      end
      OP_POP_FRONT: begin
        pop_f = accept && !empty;
      end
      OP_POP_BACK: begin
        pop_b = accept && !empty;
      end
      default: begin
        ok = !empty;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_f || push_b) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_f || pop_b) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // The front row keeps the front record in cell 0, the back row the back record.
  // A push at one end is an insert on its own row and a tail load on the other.
  assign front_ctl = '{ins_head: push_f, drop_head: pop_f, put_tail: push_b};
  assign back_ctl  = '{ins_head: push_b, drop_head: pop_b, put_tail: push_f};

  rbd_chain #(.DEPTH(DEPTH), .CNT_W(CNT_W)) u_front_chain (
    .clk   (clk),
    .ctl   (front_ctl),
    .cnt   (cnt_r),
    .d_new (new_rec),
    .head  (front_rec)
  );

  rbd_chain #(.DEPTH(DEPTH), .CNT_W(CNT_W)) u_back_chain (
    .clk   (clk),
    .ctl   (back_ctl),
    .cnt   (cnt_r),
    .d_new (new_rec),
    .head  (back_rec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_ok_r    <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
        out_ok_r    <= ok;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_count       = cnt_r;
  assign out_not_empty   = !empty;
  assign out_front_id    = empty ? '0 : front_rec.id;
  assign out_front_grade = empty ? '0 : front_rec.grade;
  assign out_back_id     = empty ? '0 : back_rec.id;
  assign out_back_grade  = empty ? '0 : back_rec.grade;

endmodule

### design/rbd_cell.sv
module rbd_cell (
  input  logic             clk,
  input  rbd_pkg::cell_op_t op,
  input  rbd_pkg::rec_t    d_left,
  input  rbd_pkg::rec_t    d_right,
  input  rbd_pkg::rec_t    d_new,
  output rbd_pkg::rec_t    q
);
  import rbd_pkg::*;

  rec_t q_r;
  rec_t q_nxt;

  always_comb begin
    case (op)
      CELL_HOLD:       q_nxt = q_r;
      CELL_FROM_LEFT:  q_nxt = d_left;
      CELL_FROM_RIGHT: q_nxt = d_right;
      CELL_LOAD:       q_nxt = d_new;
      default:         q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

### design/rbd_chain.sv
module rbd_chain #(
  parameter int DEPTH = 16,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  rbd_pkg::chain_ctl_t ctl,
  input  logic [CNT_W-1:0]    cnt,
  input  rbd_pkg::rec_t       d_new,
  output rbd_pkg::rec_t       head
);
  import rbd_pkg::*;

  rec_t     q   [DEPTH];
  cell_op_t op  [DEPTH];
  rec_t     lft [DEPTH];
  rec_t     rgt [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lft[i] = d_new;
    end else begin : g_mid
      assign lft[i] = q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rgt[i] = '0;
    end else begin : g_inner
      assign rgt[i] = q[i+1];
    end

    // Cell 0 takes the new record on an insert; the others take their left neighbor.
    always_comb begin
      if (ctl.ins_head) begin
        op[i] = (i == 0) ? CELL_LOAD : CELL_FROM_LEFT;
      end else if (ctl.drop_head) begin
        op[i] = CELL_FROM_RIGHT;
      end else if (ctl.put_tail && (cnt == CNT_W'(i))) begin
        op[i] = CELL_LOAD;
      end else begin
        op[i] = CELL_HOLD;
      end
    end

    rbd_cell u_cell (
      .clk     (clk),
      .op      (op[i]),
      .d_left  (lft[i]),
      .d_right (rgt[i]),
      .d_new   (d_new),
      .q       (q[i])
    );
  end

  assign head = q[0];

endmodule

### design/rbd_checker.sv
module rbd_checker #(
  parameter int DEPTH = 16,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_ok,
  input logic [CNT_W-1:0]   out_count,
  input logic               out_not_empty,
  input logic signed [31:0] out_front_id,
  input logic [31:0]        out_front_grade,
  input logic signed [31:0] out_back_id,
  input logic [31:0]        out_back_grade
);

  // An accepted item always has its result shown at the next edge.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted item produced no result");

  // The input side waits only while a result is held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= CNT_W'(DEPTH)) && (out_not_empty == (out_count != '0)))
    else $error("count out of range or inconsistent with not_empty");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_not_empty) |-> (out_front_id == '0) && (out_front_grade == '0)
      && (out_back_id == '0) && (out_back_grade == '0))
    else $error("empty result carries nonzero records");

  // Between two back-to-back results, a refused operation leaves the count unchanged.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && $past(out_valid && !out_stall) && !out_ok)
      |-> $stable(out_count) || (out_count == $past(out_count)))
    else $error("refused operation changed the count");

endmodule

bind ring_buffer_deque_top rbd_checker #(.DEPTH(DEPTH)) u_rbd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_ok          (out_ok),
  .out_count       (out_count),
  .out_not_empty   (out_not_empty),
  .out_front_id    (out_front_id),
  .out_front_grade (out_front_grade),
  .out_back_id     (out_back_id),
  .out_back_grade  (out_back_grade)
);
